// ===== rtl/sitda_pkg.sv =====
// Shared constants for the signed integer to decimal ASCII converter.
// No dependencies; imported by the converter, its checker and the bench.
package sitda_pkg;

    localparam int VALUE_BITS = 32;
    // Decimal digits needed for a VALUE_BITS-bit magnitude (log10(2) ~ 0.30103).
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int NDIG_W     = $clog2(DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text converter, streaming in and out.
// Steps: a double-dabble pass over the VALUE_BITS magnitude bits, then leading zeros
// dropped, a minus sign for a negative value, then one character per cycle (1 to 11)
// while the sink does not stall. A new value is taken only in idle, once the last
// character of the previous one is in the one-character output register.
// Reset: rst_n asynchronous, active low; returns to idle with no output valid.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_BITS-1:0] s_tdata,   // [31:0] value (signed)
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] char_code
    output logic                  m_tlast    // last_char
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t              state_reg,  state_next;
    logic [VALUE_BITS-1:0] bin_reg,  bin_next;
    logic [BCD_W-1:0]    bcd_reg,    bcd_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [NDIG_W-1:0]   ndig_reg,   ndig_next;
    logic                neg_reg,    neg_next;
    logic                valid_reg,  valid_next;
    logic [7:0]          data_reg,   data_next;
    logic                last_reg,   last_next;

    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          top_digit;
    logic                slot_free;
    logic                in_xfer;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;
    assign m_tlast   = last_reg;

    // The output register can take a new character when empty or draining.
    assign slot_free = !valid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Add-3 unit: correct every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        ndig_next  = ndig_reg;
        neg_next   = neg_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        // Drop the held character once the sink takes it.
        valid_next = valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next   = s_tdata[VALUE_BITS-1];
                    // Unsigned magnitude; the most negative value maps to itself.
                    bin_next   = s_tdata[VALUE_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Shift one magnitude bit into the corrected BCD word.
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    ndig_next  = NDIG_W'(DIGITS);
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // Skip leading zero digits, always keeping at least one.
                if (top_digit == 4'd0 && ndig_reg != NDIG_W'(1))
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_EMIT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    valid_next = 1'b1;
                    data_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    valid_next = 1'b1;
                    data_next  = CHAR_ZERO + {4'd0, top_digit};
                    last_next  = (ndig_reg == NDIG_W'(1));
                    bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next  = ndig_reg - 1'b1;
                    if (ndig_reg == NDIG_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid flag are reset; payload registers need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        ndig_reg <= ndig_next;
        neg_reg  <= neg_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/sitda_checker.sv =====
// Port-level checker for the signed integer to decimal ASCII converter.
// Depends on sitda_pkg; bound to signed_int_to_decimal_ascii below.
module sitda_checker
    import sitda_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [VALUE_BITS-1:0] s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata,
    input logic                  m_tlast
);

    // A stalled output transfer holds its character and mark.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // One item at a time: the input closes right after a transfer.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again during conversion");

    // Only a minus sign or a decimal digit is ever shown.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS) ||
                     (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE))
        else $error("invalid character code");

    // A sign is always followed by at least one digit.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast)
        else $error("sign marked as last character");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb_top.sv =====
// Self-checking bench for signed_int_to_decimal_ascii: signed values in, ASCII digit transfers out.
// Depends on sitda_pkg and the converter RTL. Each expected character string comes from
// a local predictor and is matched in order against the output stream.
module tb_top;
    import sitda_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata;   // [31:0] value (signed)
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [7:0] char_code
    logic                  m_tlast;   // last_char

    // Characters still owed by the converter, oldest at the front
    char_t char_q[$];
    int    fail_count;
    // Hold both sides busy (no idle cycles, no output stalls) while set
    bit    steady;

    signed_int_to_decimal_ascii u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Kill the run if the converter hangs; far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    // Work out the decimal text of one value and queue its characters, sign first.
    // Take the magnitude as unsigned so the most negative value needs no special path.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [7:0]            digit_rev[DIGITS];
        int                    n;
        char_t                 c;
        mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        n = 0;
        // Peel digits from the least significant end; zero still yields one digit
        do
        begin
            digit_rev[n] = CHAR_ZERO + 8'(mag % 10);
            mag = mag / 10;
            n++;
        end
        while (mag != 0);
        if (value[VALUE_BITS-1])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            char_q.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            c.code = digit_rev[k];
            c.last = (k == 0);
            char_q.push_back(c);
        end
    endfunction

    // Count a failure; print only the first ten
    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    // Drive one value and hold it until the converter takes the transfer.
    // Entered and left at a falling edge, so s_tvalid gets one update per step.
    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        while (!steady && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predict_text(value);
        @(negedge clk);
    endtask

    // Pick a value with a spread of digit counts, signs and all 32 bits exercised
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] pow;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(99);
            2: v = $urandom >> $urandom_range(VALUE_BITS - 1);
            default:
            begin
                // Land right on or next to a power of ten, where the digit count steps
                pow = 1;
                repeat ($urandom_range(9)) pow = pow * 10;
                v = pow + $urandom_range(2) - 1;
            end
        endcase
        if ($urandom_range(1))
            v = ~v + 1'b1;
        return v;
    endfunction

    // Lower valid and wait until every owed character has come out,
    // then give the converter a full conversion time to show any stray output
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (char_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Extremes, digit count boundaries and the most negative value
    task automatic test_directed();
        logic [VALUE_BITS-1:0] pattern[$];
        pattern = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                    32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd5,
                    32'h5555_5555, 32'hAAAA_AAAA, -32'sd1000000000, 32'd4294967};
        foreach (pattern[i])
            send_value(pattern[i]);
        drain_results();
    endtask

    // Random values with random idling on both sides
    task automatic test_random_values();
        repeat (180)
            send_value(pick_value());
        drain_results();
    endtask

    // Long stretch of back-to-back transfers with the output never stalled
    task automatic test_full_rate();
        steady = 1'b1;
        repeat (80)
            send_value(pick_value());
        drain_results();
        steady = 1'b0;
    endtask

    // Output side: stall at random unless a full-rate stretch is running
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= steady || ($urandom_range(99) >= 30);
        end
    end

    // Compare every output transfer with the oldest owed character
    always @(posedge clk)
    begin : check_output
        char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (char_q.size() == 0)
                note_mismatch($sformatf("unexpected char %0d last %0b", m_tdata, m_tlast));
            else
            begin
                want = char_q.pop_front();
                if (m_tdata !== want.code || m_tlast !== want.last)
                    note_mismatch($sformatf("char %0d last %0b, expected char %0d last %0b",
                                            m_tdata, m_tlast, want.code, want.last));
            end
        end
    end

    initial
    begin
        fail_count = 0;
        steady     = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_values();
        test_full_rate();

        if (char_q.size() != 0)
            note_mismatch($sformatf("%0d characters never arrived", char_q.size()));
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
rtl/sitda_pkg.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sitda_checker.sv
test/tb_top.sv
